### rtl/core/dstq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstq_pkg
// Shared types and constants for the deadline sorted timer queue unit.
// ----------------------------------------------------------------------------
package dstq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 16;
  localparam int HANDLE_BITS = 16;
  localparam int DELAY_BITS  = 32;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_CLEAR    = 2'd1,
    OP_TICK     = 2'd2,
    OP_RELEASE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_TASK   = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic pop;
    logic empty;
    logic last;
  } dstq_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  in_op;
    logic out_free;
    logic head_due;
    logic next_due;
  } dstq_sts_t;

endpackage : dstq_pkg
`default_nettype wire

### rtl/core/dstq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstq_ctrl
// Controller: accepts one request at a time, sequences the operation and
// the release loop that pops one due task per result.
// ----------------------------------------------------------------------------
module dstq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire dstq_pkg::dstq_sts_t sts,
  output dstq_pkg::dstq_cmd_t     cmd
);
  import dstq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_REL  = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   rel_count, rel_count_next;
  logic               rel_last;

  assign req_stall = (state != S_IDLE);

  // final pop when the result budget is used up or the next entry is not due
  assign rel_last = (rel_count == CNT_W'(MAX_RESULTS - 1)) || !sts.next_due;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    rel_count_next = rel_count;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch      = 1'b1;
          rel_count_next = '0;
          state_next     = (sts.in_op == OP_RELEASE) ? S_REL : S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REL: begin
        if (sts.out_free) begin
          if (sts.head_due) begin
            cmd.pop  = 1'b1;
            cmd.last = rel_last;
            if (rel_last) begin
              state_next = S_IDLE;
            end else begin
              rel_count_next = rel_count + 1'b1;
            end
          end else begin
            cmd.empty  = 1'b1;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rel_count <= '0;
    end else begin
      state     <= state_next;
      rel_count <= rel_count_next;
    end
  end

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec || cmd.pop || cmd.empty) |-> sts.out_free)
    else $error("result issued while output register occupied");

  a_empty_only_first: assert property (@(posedge clk) disable iff (rst)
    cmd.empty |-> (rel_count == '0))
    else $error("empty release result after a task was released");

  a_last_pop_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop && cmd.last) |=> (state == S_IDLE))
    else $error("release loop continued after last transfer");

endmodule : dstq_ctrl
`default_nettype wire

### rtl/core/dstq_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dstq_chain
// Datapath: shifting sorted chain of due times and handles, the millisecond
// counter, the delay limit register and the result register.
// ----------------------------------------------------------------------------
module dstq_chain (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [dstq_pkg::DELAY_BITS-1:0] cfg_wdata,
  input  wire logic [1:0]                    operation,
  input  wire logic [dstq_pkg::HANDLE_BITS-1:0] task_handle,
  input  wire logic [dstq_pkg::DELAY_BITS-1:0] offset_ms,
  input  wire dstq_pkg::dstq_cmd_t           cmd,
  output dstq_pkg::dstq_sts_t                sts,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output logic [1:0]                         kind,
  output logic [dstq_pkg::HANDLE_BITS-1:0]   released_handle,
  output logic [1:0]                         status,
  output logic                               tasks_pending,
  output logic                               last
);
  import dstq_pkg::*;

  logic [TIME_BITS-1:0]   due_times [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] handles   [QUEUE_DEPTH];
  logic [OCC_W-1:0]       occupancy;
  logic [TIME_BITS-1:0]   now_counter;
  logic [DELAY_BITS-1:0]  max_delay;

  op_t                    op_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic [DELAY_BITS-1:0]  delay_r;
  logic [TIME_BITS-1:0]   due_r;

  logic [TIME_BITS:0]     due_sum;
  logic                   sched_invalid, sched_full, sched_ok;
  logic [QUEUE_DEPTH-1:0] le;
  logic [TIME_BITS-1:0]   ins_due    [QUEUE_DEPTH];
  logic [HANDLE_BITS-1:0] ins_handle [QUEUE_DEPTH];
  logic                   load;
  logic                   out_free;
  status_t                exec_status;
  logic                   exec_pending;

  // due time of the incoming request, saturated to the counter width
  assign due_sum = {1'b0, now_counter} + (TIME_BITS + 1)'(offset_ms);

  assign sched_invalid = (handle_r == '0) || (delay_r > max_delay);
  assign sched_full    = (occupancy >= OCC_W'(QUEUE_DEPTH));
  assign sched_ok      = !sched_invalid && !sched_full;

  // entries due no later than the new one form a prefix of the chain
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le[i] = (OCC_W'(i) < occupancy) && (due_times[i] <= due_r);
    end
    ins_due[0]    = le[0] ? due_times[0] : due_r;
    ins_handle[0] = le[0] ? handles[0]   : handle_r;
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      if (le[i]) begin
        ins_due[i]    = due_times[i];
        ins_handle[i] = handles[i];
      end else if (le[i-1]) begin
        ins_due[i]    = due_r;
        ins_handle[i] = handle_r;
      end else begin
        ins_due[i]    = due_times[i-1];
        ins_handle[i] = handles[i-1];
      end
    end
  end

  always_comb begin
    exec_status  = ST_OK;
    exec_pending = (occupancy != '0);
    case (op_r)
      OP_SCHEDULE: begin
        if (sched_invalid) begin
          exec_status = ST_INVALID;
        end else if (sched_full) begin
          exec_status = ST_FULL;
        end else begin
          exec_pending = 1'b1;
        end
      end
      OP_CLEAR: exec_pending = 1'b0;
      default:  exec_pending = (occupancy != '0);
    endcase
  end

  assign out_free = !rsp_valid || !rsp_stall;
  assign load     = cmd.exec || cmd.pop || cmd.empty;

  assign sts.in_op    = op_t'(operation);
  assign sts.out_free = out_free;
  assign sts.head_due = (occupancy != '0) && (now_counter >= due_times[0]);
  assign sts.next_due = (occupancy > OCC_W'(1)) && (now_counter >= due_times[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_delay <= '1;
    end else if (cfg_we) begin
      max_delay <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= op_t'(operation);
      handle_r <= task_handle;
      delay_r  <= offset_ms;
      due_r    <= due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy   <= '0;
      now_counter <= '0;
    end else if (cmd.exec) begin
      case (op_r)
        OP_SCHEDULE: if (sched_ok) occupancy <= occupancy + 1'b1;
        OP_CLEAR:    occupancy <= '0;
        OP_TICK:     now_counter <= now_counter + 1'b1;
        default:     occupancy <= occupancy;
      endcase
    end else if (cmd.pop) begin
      occupancy <= occupancy - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && (op_r == OP_SCHEDULE) && sched_ok) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        due_times[i] <= ins_due[i];
        handles[i]   <= ins_handle[i];
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        due_times[i] <= due_times[i+1];
        handles[i]   <= handles[i+1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      kind            <= KIND_TASK;
      released_handle <= handles[0];
      status          <= ST_OK;
      tasks_pending   <= (occupancy > OCC_W'(1));
      last            <= cmd.last;
    end else if (cmd.empty) begin
      kind            <= KIND_EMPTY;
      released_handle <= '0;
      status          <= ST_OK;
      tasks_pending   <= (occupancy != '0);
      last            <= 1'b1;
    end else if (cmd.exec) begin
      kind            <= KIND_STATUS;
      released_handle <= '0;
      status          <= exec_status;
      tasks_pending   <= exec_pending;
      last            <= 1'b1;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= OCC_W'(QUEUE_DEPTH))
    else $error("queue occupancy above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (occupancy != '0) && (now_counter >= due_times[0]))
    else $error("pop of an empty or not yet due head");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && (op_r == OP_TICK)) |=>
      (now_counter == TIME_BITS'($past(now_counter) + 1'b1)))
    else $error("tick did not advance the counter");

endmodule : dstq_chain
`default_nettype wire

### rtl/core/deadline_sorted_timer_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue_unit
// Bounded queue of task handles kept sorted by due time, with a millisecond
// counter; schedule, clear, tick and release of due tasks.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  req       req_valid / req_stall  operation, task_handle, offset_ms
//  rsp       rsp_valid / rsp_stall  kind, released_handle, status,
//                                   tasks_pending, last
//  cfg       cfg_we                 cfg_wdata (max_delay)
//
//  schedule, clear and tick: the accept cycle adds the delay to the counter;
//  S_EXEC then inserts into the shifting chain in one step, clears or ticks.
//  release: the chain pops one head a cycle while the result register is free.
//  the result register lets the next request in while a result waits;
//  rsp_stall holds the controller before it issues its next result.
//  synchronous reset empties the queue, zeroes the counter and sets
//  max_delay to all ones; no clearing pass is needed.
// ----------------------------------------------------------------------------
module deadline_sorted_timer_queue_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [dstq_pkg::DELAY_BITS-1:0]   cfg_wdata,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic [1:0]                        operation,
  input  wire logic [dstq_pkg::HANDLE_BITS-1:0]  task_handle,
  input  wire logic [dstq_pkg::DELAY_BITS-1:0]   offset_ms,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic [1:0]                             kind,
  output logic [dstq_pkg::HANDLE_BITS-1:0]       released_handle,
  output logic [1:0]                             status,
  output logic                                   tasks_pending,
  output logic                                   last
);
  import dstq_pkg::*;

  dstq_cmd_t cmd;
  dstq_sts_t sts;

  dstq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dstq_chain u_chain (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .operation       (operation),
    .task_handle     (task_handle),
    .offset_ms       (offset_ms),
    .cmd             (cmd),
    .sts             (sts),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .kind            (kind),
    .released_handle (released_handle),
    .status          (status),
    .tasks_pending   (tasks_pending),
    .last            (last)
  );

endmodule : deadline_sorted_timer_queue_unit
`default_nettype wire
